### design/hex_char_reference_unescaper_assert.svh
// Assertion macros shared by the hex character reference unescaper.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef HEX_CHAR_REFERENCE_UNESCAPER_ASSERT_SVH
`define HEX_CHAR_REFERENCE_UNESCAPER_ASSERT_SVH

// Checked only while out of reset.
`define HCRU_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcru assertion failed");

// Checked at every clock edge, reset included.
`define HCRU_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hcru assertion failed");

`endif

### design/hcru_pkg.sv
// Shared types, character constants and hex helpers for the unescaper.
// No dependencies; imported by every module of the block.
package hcru_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] AlphaGap  = 8'h27;
  localparam logic [7:0] CaseGap   = 8'h20;

  typedef logic [2:0] held_cnt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_t;

  // One classified input transaction: held bytes to release, then an optional tail byte.
  typedef struct packed {
    held_cnt_t  held_cnt;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic       tail_vld;
    logic [7:0] tail_byte;
    logic       last;
  } job_t;

  typedef struct packed {
    logic push;
    logic idle;
  } fe_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v >= 8'h41 && v <= 8'h5A) begin
      v = v + CaseGap;
    end
    v = v - DigitBase;
    if (v > 8'd9) begin
      v = v - AlphaGap;
    end
    return v[3:0];
  endfunction

endpackage

### design/hex_char_reference_unescaper.sv
// The edge that accepts a transaction writes its job into the queue, and the back end
// then loads the first result from the queue into the output register.
// Throughput: one input byte per cycle while the job queue has room; the back end emits
// one byte per cycle while the output is accepted, one for each result of a job.
// A full decoded pattern takes six inputs and yields one output.
// Reset (asynchronous, active low) clears the match state, the queue and the output valid.
module hex_char_reference_unescaper #(
  parameter int unsigned FifoDepth = hcru_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hcru_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hcru_pkg::out_t out_data_o
);
  import hcru_pkg::*;

`include "hex_char_reference_unescaper_assert.svh"

  job_t       fe_job, be_job;
  fe_status_t fe_status;
  logic       fifo_full, fifo_empty, be_pop;

  hcru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .job_o       (fe_job),
    .status_o    (fe_status)
  );

  hcru_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_status.push),
    .data_i  (fe_job),
    .full_o  (fifo_full),
    .pop_i   (be_pop),
    .empty_o (fifo_empty),
    .data_o  (be_job)
  );

  hcru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (!fifo_empty),
    .job_i       (be_job),
    .pop_o       (be_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The output register never shows a transaction while reset is applied.
  `HCRU_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o)
  // A stream end is always the final result of its input transaction.
  `HCRU_ASSERT(a_stream_last_is_run_last, clk_i, rst_ni,
               out_valid_o && out_data_o.stream_last |-> out_data_o.run_last)
  // After the last byte of a stream the matcher holds nothing.
  `HCRU_ASSERT(a_idle_after_last, clk_i, rst_ni,
               in_valid_i && in_ready_o && in_data_i.in_last |=> fe_status.idle)
  // The front never pushes into a full queue.
  `HCRU_ASSERT(a_no_push_when_full, clk_i, rst_ni, fifo_full |-> !fe_status.push)

endmodule

### design/hcru_fifo.sv
// Small register queue that carries classified transactions from front to back.
// Depends on hcru_pkg for the job type.
module hcru_fifo #(
  parameter int unsigned Depth = hcru_pkg::FifoDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcru_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output hcru_pkg::job_t  data_o
);
  import hcru_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/hcru_front.sv
// Front end: classifying pattern matcher, one byte per cycle while the queue has room.
// Depends on hcru_pkg; feeds hcru_fifo with one job per transaction that has results.
module hcru_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hcru_pkg::in_t       in_data_i,
  input  logic                fifo_full_i,
  output hcru_pkg::job_t      job_o,
  output hcru_pkg::fe_status_t status_o
);
  import hcru_pkg::*;

  // Encoding equals the number of pattern bytes held.
  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhAmp  = 3'd1,
    PhHash = 3'd2,
    PhX    = 3'd3,
    PhDig1 = 3'd4,
    PhDig2 = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d, phase_adv;
  logic [7:0] digit1_q, digit1_d;
  logic [7:0] digit2_q, digit2_d;
  logic       accept, ok, idle_tail;
  logic [7:0] b;
  logic       last;
  job_t       job;

  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.in_last;
  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  // A byte handled with no match in progress: an ampersand is held unless the stream ends.
  assign idle_tail  = (b != ChAmp) || last;

  always_comb begin
    ok        = 1'b1;
    phase_adv = PhIdle;
    digit1_d  = digit1_q;
    digit2_d  = digit2_q;
    unique case (phase_q)
      PhAmp: begin
        ok        = (b == ChHash);
        phase_adv = PhHash;
      end
      PhHash: begin
        ok        = (b == ChLowX);
        phase_adv = PhX;
      end
      PhX: begin
        ok        = is_hex(b);
        phase_adv = PhDig1;
        if (ok) begin
          digit1_d = b;
        end
      end
      PhDig1: begin
        ok        = is_hex(b);
        phase_adv = PhDig2;
        if (ok) begin
          digit2_d = b;
        end
      end
      PhDig2: begin
        ok        = (b == ChSemi);
        phase_adv = PhIdle;
      end
      default: begin
        ok        = 1'b1;
        phase_adv = PhIdle;
      end
    endcase
  end

  always_comb begin
    job.held_cnt  = '0;
    job.digit1    = digit1_d;
    job.digit2    = digit2_d;
    job.tail_vld  = 1'b0;
    job.tail_byte = b;
    job.last      = last;
    phase_d       = phase_q;
    priority if (phase_q == PhIdle || !ok) begin
      // A broken match releases what is held, then the byte is taken as if idle.
      job.held_cnt = (phase_q == PhIdle) ? '0 : held_cnt_t'(phase_q);
      job.tail_vld = idle_tail;
      phase_d      = (b == ChAmp && !last) ? PhAmp : PhIdle;
    end else if (phase_q == PhDig2) begin
      job.tail_vld  = 1'b1;
      job.tail_byte = {hex_nibble(digit1_q), hex_nibble(digit2_q)};
      phase_d       = PhIdle;
    end else if (last) begin
      job.held_cnt = held_cnt_t'(phase_adv);
      phase_d      = PhIdle;
    end else begin
      phase_d = phase_adv;
    end
  end

  assign job_o           = job;
  assign status_o.push   = accept && (job.held_cnt != '0 || job.tail_vld);
  assign status_o.idle   = (phase_q == PhIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      digit1_q <= '0;
      digit2_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      digit1_q <= digit1_d;
      digit2_q <= digit2_d;
    end
  end

endmodule

### design/hcru_back.sv
// Back end: expands queued jobs into output bytes, one per cycle unless stalled.
// Depends on hcru_pkg; drains hcru_fifo and drives the registered output channel.
module hcru_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_vld_i,
  input  hcru_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hcru_pkg::out_t  out_data_o
);
  import hcru_pkg::*;

  logic       out_valid_q;
  out_t       out_q, out_d;
  held_cnt_t  idx_q, idx_d;
  held_cnt_t  total;
  logic       load, final_elem;
  logic [7:0] held_byte, elem_byte;

  // Results of a job: held_cnt released pattern bytes, then the tail byte if any.
  assign total      = job_i.held_cnt + held_cnt_t'(job_i.tail_vld);
  assign final_elem = (idx_q == total - 1'b1);
  assign load       = job_vld_i && (!out_valid_q || out_ready_i);
  assign pop_o      = load && final_elem;

  always_comb begin
    unique case (idx_q)
      3'd0:    held_byte = ChAmp;
      3'd1:    held_byte = ChHash;
      3'd2:    held_byte = ChLowX;
      3'd3:    held_byte = job_i.digit1;
      default: held_byte = job_i.digit2;
    endcase
    elem_byte = (idx_q < job_i.held_cnt) ? held_byte : job_i.tail_byte;

    out_d.out_byte    = elem_byte;
    out_d.run_last    = final_elem;
    out_d.stream_last = final_elem && job_i.last;
    idx_d             = final_elem ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= idx_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/hex_char_reference_unescaper_tb.sv
// Self-checking testbench for hex_char_reference_unescaper: a directed and random byte stream
// goes in, and every output transaction is compared with an in-bench decoder.
// Depends on hcru_pkg and the design top; the checker class lives in hcru_check_pkg below.
`timescale 1ns / 1ps

package hcru_check_pkg;
  import hcru_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AMP,
    PH_HASH,
    PH_X,
    PH_D1,
    PH_D2
  } match_phase_e;

  class decoded_stream_checker;
    match_phase_e phase;
    logic [7:0]   hi_char;
    logic [7:0]   lo_char;
    out_t         expected_q[$];
    int unsigned  n_inputs;
    int unsigned  n_checked;
    int unsigned  n_decoded;
    int unsigned  n_flushes;
    int unsigned  n_errors;

    function new();
      phase     = PH_IDLE;
      hi_char   = '0;
      lo_char   = '0;
      n_inputs  = 0;
      n_checked = 0;
      n_decoded = 0;
      n_flushes = 0;
      n_errors  = 0;
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      if (c >= "a") begin
        v = c - "a" + 8'd10;
      end else if (c >= "A") begin
        v = c - "A" + 8'd10;
      end else begin
        v = c - "0";
      end
      return v[3:0];
    endfunction

    function void push_byte(logic [7:0] b);
      out_t r;
      r.out_byte    = b;
      r.run_last    = 1'b0;
      r.stream_last = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Held pattern bytes come back out in the order they arrived.
    function void release_held();
      if (phase >= PH_AMP) push_byte(ChAmp);
      if (phase >= PH_HASH) push_byte(ChHash);
      if (phase >= PH_X) push_byte(ChLowX);
      if (phase >= PH_D1) push_byte(hi_char);
      if (phase >= PH_D2) push_byte(lo_char);
      phase = PH_IDLE;
    endfunction

    function void take_idle(logic [7:0] b);
      if (b == ChAmp) begin
        phase = PH_AMP;
      end else begin
        phase = PH_IDLE;
        push_byte(b);
      end
    endfunction

    function void note_input(in_t item);
      int unsigned first;
      bit          ok;
      logic [7:0]  b;
      out_t        tail;
      first = expected_q.size();
      b     = item.in_byte;
      ok    = 1'b1;
      n_inputs++;
      case (phase)
        PH_AMP: begin
          if (b == ChHash) phase = PH_HASH;
          else ok = 1'b0;
        end
        PH_HASH: begin
          if (b == ChLowX) phase = PH_X;
          else ok = 1'b0;
        end
        PH_X: begin
          if (is_hex_char(b)) begin
            hi_char = b;
            phase   = PH_D1;
          end else begin
            ok = 1'b0;
          end
        end
        PH_D1: begin
          if (is_hex_char(b)) begin
            lo_char = b;
            phase   = PH_D2;
          end else begin
            ok = 1'b0;
          end
        end
        PH_D2: begin
          if (b == ChSemi) begin
            push_byte({nibble_of(hi_char), nibble_of(lo_char)});
            phase = PH_IDLE;
            n_decoded++;
          end else begin
            ok = 1'b0;
          end
        end
        default: take_idle(b);
      endcase
      // A broken match lets the breaking byte start over from idle.
      if (!ok) begin
        release_held();
        take_idle(b);
      end
      if (item.in_last) begin
        if (phase != PH_IDLE) n_flushes++;
        release_held();
      end
      if (expected_q.size() > first) begin
        tail             = expected_q.pop_back();
        tail.run_last    = 1'b1;
        tail.stream_last = item.in_last;
        expected_q.push_back(tail);
      end
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_output(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, actual %02h/%0b/%0b",
                 $time, got.out_byte, got.run_last, got.stream_last);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      report_field("out_byte", want.out_byte, got.out_byte);
      report_field("run_last", want.run_last, got.run_last);
      report_field("stream_last", want.stream_last, got.stream_last);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

module hex_char_reference_unescaper_tb;
  import hcru_pkg::*;
  import hcru_check_pkg::*;

  localparam int unsigned RandomItems = 330;
  localparam int unsigned CycleLimit  = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  decoded_stream_checker sb;
  int unsigned           items_sent;
  int unsigned           cycle_count;
  bit                    tx_quiet;
  bit                    rx_quiet;

  hex_char_reference_unescaper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none at all in quiet stretches.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned idx, logic [7:0] d1, logic [7:0] d2);
    case (idx)
      0: return ChAmp;
      1: return ChHash;
      2: return ChLowX;
      3: return d1;
      4: return d2;
      default: return ChSemi;
    endcase
  endfunction

  // Called at a clock edge; returns at the edge that accepts the transaction.
  task automatic send_item(logic [7:0] b, bit last);
    int unsigned gap;
    in_t         item;
    gap            = pick_gap(tx_quiet);
    item.in_byte   = b;
    item.in_last   = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic send_text(string s, bit last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], last_on_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_prefix(int unsigned len, logic [7:0] d1, logic [7:0] d2, bit last_on_end);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pattern_byte(i, d1, d2), last_on_end && (i == len - 1));
    end
  endtask

  task automatic run_random();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  breaker;
    while (items_sent < 23 + RandomItems) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      d1   = rand_hex_char();
      d2   = rand_hex_char();
      if (kind < 50) begin
        send_prefix(6, d1, d2, $urandom_range(0, 9) == 0);
      end else if (kind < 70) begin
        len  = $urandom_range(1, 5);
        pick = $urandom_range(0, 4);
        case (pick)
          0: breaker = ChAmp;
          1: breaker = "X";
          2: breaker = ChSemi;
          3: breaker = rand_hex_char();
          default: breaker = 8'($urandom_range(0, 255));
        endcase
        send_prefix(len, d1, d2, 1'b0);
        send_item(breaker, 1'b0);
      end else if (kind < 90) begin
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end else begin
        // End of stream in the middle of a pattern, or on a lone random byte.
        len = $urandom_range(0, 5);
        if (len == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
        else send_prefix(len, d1, d2, 1'b1);
      end
    end
  endtask

  initial begin
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_output(out_data_o);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap(rx_quiet);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    items_sent = 0;
    sb         = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: plain decode, a decoded ampersand that must not restart a match,
    // ampersand breaking a match, uppercase X, byte extremes, and a flush at end of stream.
    send_text("&#x41;", 1'b0);
    send_text("&#x26;", 1'b0);
    send_text("#", 1'b0);
    send_text("&&#X", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("&#xa", 1'b1);

    run_random();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d input bytes; checked %0d output bytes.", sb.n_inputs, sb.n_checked);
    $display("Saw %0d decoded references and %0d partial matches flushed at end of stream.",
             sb.n_decoded, sb.n_flushes);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
